### sv/hhs_pkg.sv
// ----------------------------------------------------------------------------
// hhs_pkg
// Shared types, codes and defaults for the hopscotch hash set.
// ----------------------------------------------------------------------------
package hhs_pkg;

  // default geometry
  localparam int TableSizeDef = 1024;
  localparam int HopRangeDef  = 32;
  localparam int AddRangeDef  = 256;

  // field widths fixed by the item format
  localparam int KeyW    = 32;
  localparam int ActionW = 2;
  localparam int StatusW = 3;

  // action codes
  localparam logic [ActionW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActionW-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ActionW-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ActionW-1:0] ACT_UNUSED = 2'd3;

  // result status codes
  localparam logic [StatusW-1:0] ST_PRESENT = 3'd0;
  localparam logic [StatusW-1:0] ST_DONE    = 3'd1;
  localparam logic [StatusW-1:0] ST_MISSING = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd3;
  localparam logic [StatusW-1:0] ST_ZERO    = 3'd4;

  // source of the reported slot
  typedef enum logic [1:0] {
    POS_ZERO,
    POS_CUR,
    POS_FREE
  } pos_sel_e;

  // what the table write port stores
  typedef enum logic [1:0] {
    WR_ZERO_CUR,
    WR_ZERO_CAND,
    WR_MOVE,
    WR_INSERT
  } wr_sel_e;

  // controller to datapath
  typedef struct packed {
    logic                load;
    logic                rd;
    logic                rd_cand;
    logic                wr;
    wr_sel_e             wr_sel;
    logic                cur_home;
    logic                cur_next;
    logic                set_free;
    logic                cand_init;
    logic                cand_next;
    logic                free_from_cand;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                res_set;
    logic [StatusW-1:0]  res_status;
    pos_sel_e            res_pos;
    logic                res_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic               key_zero;
    logic [ActionW-1:0] action;
    logic               hit;
    logic               empty;
    logic               find_end;
    logic               add_end;
    logic               far;
    logic               can_move;
    logic               step_last;
    logic               clr_last;
    logic               out_free;
  } dp_sts_t;

endpackage

### sv/hhs_if.sv
// ----------------------------------------------------------------------------
// hhs_in_if / hhs_out_if
// Valid/ready channels for requests and results of the hash set.
// ----------------------------------------------------------------------------
interface hhs_in_if
  import hhs_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [ActionW-1:0]        action;
  logic signed [KeyW-1:0]    key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface hhs_out_if
  import hhs_pkg::*;
#(
  parameter int IdxW = $clog2(TableSizeDef)
) ();
  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [IdxW-1:0]     position;
  logic [IdxW:0]       occupied_count;

  modport source (output valid, output status, output position, output occupied_count,
                  input ready);
  modport sink   (input valid, input status, input position, input occupied_count,
                  output ready);
endinterface

### sv/hopscotch_hash_set.sv
// ----------------------------------------------------------------------------
// hopscotch_hash_set
// Hopscotch hash set of nonzero 32-bit keys with insert, lookup and remove.
// ----------------------------------------------------------------------------
// After reset the block clears every table slot in turn and takes
// no request until that pass is done. Each table slot is read through one
// registered read port, and every probe is a read state then a check state.
// A lookup or remove passes from the accepted request through a decide
// state, its probes and the handoff into the output register before the
// next request is taken, and probes at most HopRange slots. An insert first
// probes the hop window like a lookup, then scans up to AddRange slots for
// a free one, and each displacement step is a decide state, probes of up to
// HopRange-1 candidate slots and a vacate of the moved key's old slot. One
// request is in flight at a time; a finished result sits in the output
// register while the next request is accepted, and a result that is still
// unread when the next one is done stalls the block in its handoff, so the
// input stays blocked until the output register frees.
// ----------------------------------------------------------------------------
module hopscotch_hash_set
  import hhs_pkg::*;
#(
  parameter int TableSize = TableSizeDef,
  parameter int HopRange  = HopRangeDef,
  parameter int AddRange  = AddRangeDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hhs_in_if.sink    in_i,
  hhs_out_if.source out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  hhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // tables and registers
  hhs_dp #(
    .TableSize (TableSize),
    .HopRange  (HopRange),
    .AddRange  (AddRange)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (in_i.action),
    .key_i          (in_i.key),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_status_o   (out_o.status),
    .out_position_o (out_o.position),
    .out_count_o    (out_o.occupied_count)
  );

endmodule

### sv/hhs_dp.sv
// ----------------------------------------------------------------------------
// hhs_dp
// Datapath: key and hop-distance tables, probe cursors, entry count and
// the result registers.
// ----------------------------------------------------------------------------
module hhs_dp
  import hhs_pkg::*;
#(
  parameter int TableSize = TableSizeDef,
  parameter int HopRange  = HopRangeDef,
  parameter int AddRange  = AddRangeDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_sts_t                 sts_o,
  input  logic [ActionW-1:0]      action_i,
  input  logic [KeyW-1:0]         key_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [StatusW-1:0]      out_status_o,
  output logic [$clog2(TableSize)-1:0] out_position_o,
  output logic [$clog2(TableSize):0]   out_count_o
);

  localparam int IW   = $clog2(TableSize);
  localparam int DW   = $clog2(HopRange);
  localparam int DMax = (AddRange > HopRange) ? AddRange : HopRange;
  localparam int CW   = $clog2(DMax);

  // tables
  logic [KeyW-1:0] key_mem [TableSize];
  logic [DW-1:0]   hop_mem [TableSize];

  logic [KeyW-1:0]    key_q;
  logic [ActionW-1:0] act_q;
  logic [IW-1:0]      cur_q;
  logic [CW-1:0]      dist_q;
  logic [IW-1:0]      free_q;
  logic [IW-1:0]      cand_q;
  logic [DW-1:0]      step_q;
  logic [IW:0]        cnt_q;
  logic [KeyW-1:0]    rkey_q;
  logic [DW-1:0]      rhop_q;
  logic [StatusW-1:0] pend_status_q;
  logic [IW-1:0]      pend_pos_q;
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [IW-1:0]      out_pos_q;
  logic [IW:0]        out_cnt_q;

  logic [IW-1:0]   home;
  logic [IW-1:0]   free_off;
  logic [DW:0]     move_dist;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   wr_addr;
  logic [KeyW-1:0] wr_key;
  logic [DW-1:0]   wr_hop;

  assign home      = key_q[IW-1:0];
  assign free_off  = free_q - home;
  assign move_dist = {1'b0, rhop_q} + {1'b0, step_q};

  // table port muxing
  assign rd_addr = cmd_i.rd_cand ? cand_q : cur_q;

  always_comb begin
    wr_addr = cur_q;
    wr_key  = '0;
    wr_hop  = '0;
    case (cmd_i.wr_sel)
      WR_ZERO_CUR:  wr_addr = cur_q;
      WR_ZERO_CAND: wr_addr = cand_q;
      WR_MOVE: begin
        wr_addr = free_q;
        wr_key  = rkey_q;
        wr_hop  = move_dist[DW-1:0];
      end
      WR_INSERT: begin
        wr_addr = free_q;
        wr_key  = key_q;
        wr_hop  = free_off[DW-1:0];
      end
      default: wr_addr = cur_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      key_mem[wr_addr] <= wr_key;
      hop_mem[wr_addr] <= wr_hop;
    end
    if (cmd_i.rd) begin
      rkey_q <= key_mem[rd_addr];
      rhop_q <= hop_mem[rd_addr];
    end
  end

  // request and cursor registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
      act_q <= action_i;
    end
    if (cmd_i.set_free) begin
      free_q <= cur_q;
    end else if (cmd_i.free_from_cand) begin
      free_q <= cand_q;
    end
    if (cmd_i.cand_init) begin
      cand_q <= free_q - IW'(HopRange - 1);
      step_q <= DW'(HopRange - 1);
    end else if (cmd_i.cand_next) begin
      cand_q <= cand_q + 1'b1;
      step_q <= step_q - 1'b1;
    end
    if (cmd_i.res_set) begin
      pend_status_q <= cmd_i.res_status;
      case (cmd_i.res_pos)
        POS_ZERO: pend_pos_q <= '0;
        POS_CUR:  pend_pos_q <= cur_q;
        POS_FREE: pend_pos_q <= free_q;
        default:  pend_pos_q <= '0;
      endcase
    end
    if (cmd_i.res_out) begin
      out_status_q <= pend_status_q;
      out_pos_q    <= pend_pos_q;
      out_cnt_q    <= cnt_q;
    end
  end

  // probe cursor starts at zero for the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      dist_q <= '0;
    end else if (cmd_i.cur_home) begin
      cur_q  <= home;
      dist_q <= '0;
    end else if (cmd_i.cur_next) begin
      cur_q  <= cur_q + 1'b1;
      dist_q <= dist_q + 1'b1;
    end
  end

  // entry count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.res_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status toward the controller
  always_comb begin
    sts_o.key_zero  = (key_q == '0);
    sts_o.action    = act_q;
    sts_o.hit       = (rkey_q == key_q);
    sts_o.empty     = (rkey_q == '0);
    sts_o.find_end  = (dist_q == CW'(HopRange - 1)) || (cur_q == IW'(TableSize - 1));
    sts_o.add_end   = (dist_q == CW'(AddRange - 1)) || (cur_q == IW'(TableSize - 1));
    sts_o.far       = (int'(free_off) >= HopRange);
    sts_o.can_move  = (rkey_q != '0) && (int'(move_dist) <= HopRange - 1);
    sts_o.step_last = (step_q == DW'(1));
    sts_o.clr_last  = (cur_q == IW'(TableSize - 1));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_position_o = out_pos_q;
  assign out_count_o    = out_cnt_q;

  // count stays within the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= TableSize)
    else $error("entry count beyond table size");

  // count never moves both ways at once
  a_cnt_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.cnt_inc && cmd_i.cnt_dec))
    else $error("entry count increment and decrement together");

  // a moved key stays within its hop range
  a_move_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr && cmd_i.wr_sel == WR_MOVE) |-> (int'(move_dist) <= HopRange - 1))
    else $error("displacement beyond hop range");

  // an unread result is never overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overrun");

endmodule

### sv/hhs_ctrl.sv
// ----------------------------------------------------------------------------
// hhs_ctrl
// Controller: clearing pass, probe, free-slot search, displacement chain
// and result handoff.
// ----------------------------------------------------------------------------
module hhs_ctrl
  import hhs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DECIDE  = 4'd2;
  localparam logic [3:0] S_FIND_RD = 4'd3;
  localparam logic [3:0] S_FIND_CK = 4'd4;
  localparam logic [3:0] S_FREE_RD = 4'd5;
  localparam logic [3:0] S_FREE_CK = 4'd6;
  localparam logic [3:0] S_DISP    = 4'd7;
  localparam logic [3:0] S_MV_RD   = 4'd8;
  localparam logic [3:0] S_MV_CK   = 4'd9;
  localparam logic [3:0] S_MV_VAC  = 4'd10;
  localparam logic [3:0] S_RESP    = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.wr_sel     = WR_ZERO_CUR;
    cmd_o.res_pos    = POS_ZERO;
    cmd_o.res_status = ST_MISSING;
    case (state_q)
      S_CLR: begin
        cmd_o.wr       = 1'b1;
        cmd_o.cur_next = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.cur_next = 1'b0;
          state_d        = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.cur_home = 1'b1;
        if (sts_i.key_zero) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_ZERO;
          state_d          = S_RESP;
        end else if (sts_i.action == ACT_INSERT || sts_i.action == ACT_LOOKUP ||
                     sts_i.action == ACT_REMOVE) begin
          state_d = S_FIND_RD;
        end else begin
          cmd_o.res_set = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_FIND_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_FIND_CK;
      end
      S_FIND_CK: begin
        if (sts_i.hit) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_pos = POS_CUR;
          state_d       = S_RESP;
          if (sts_i.action == ACT_REMOVE) begin
            cmd_o.wr         = 1'b1;
            cmd_o.cnt_dec    = 1'b1;
            cmd_o.res_status = ST_DONE;
          end else begin
            cmd_o.res_status = ST_PRESENT;
          end
        end else if (!sts_i.find_end) begin
          cmd_o.cur_next = 1'b1;
          state_d        = S_FIND_RD;
        end else if (sts_i.action == ACT_INSERT) begin
          cmd_o.cur_home = 1'b1;
          state_d        = S_FREE_RD;
        end else begin
          cmd_o.res_set = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_FREE_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_FREE_CK;
      end
      S_FREE_CK: begin
        if (sts_i.empty) begin
          cmd_o.set_free = 1'b1;
          state_d        = S_DISP;
        end else if (sts_i.add_end) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_RESP;
        end else begin
          cmd_o.cur_next = 1'b1;
          state_d        = S_FREE_RD;
        end
      end
      S_DISP: begin
        if (sts_i.far) begin
          cmd_o.cand_init = 1'b1;
          state_d         = S_MV_RD;
        end else begin
          cmd_o.wr         = 1'b1;
          cmd_o.wr_sel     = WR_INSERT;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_DONE;
          cmd_o.res_pos    = POS_FREE;
          state_d          = S_RESP;
        end
      end
      S_MV_RD: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rd_cand = 1'b1;
        state_d       = S_MV_CK;
      end
      S_MV_CK: begin
        if (sts_i.can_move) begin
          cmd_o.wr     = 1'b1;
          cmd_o.wr_sel = WR_MOVE;
          state_d      = S_MV_VAC;
        end else if (sts_i.step_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_RESP;
        end else begin
          cmd_o.cand_next = 1'b1;
          state_d         = S_MV_RD;
        end
      end
      S_MV_VAC: begin
        cmd_o.wr             = 1'b1;
        cmd_o.wr_sel         = WR_ZERO_CAND;
        cmd_o.free_from_cand = 1'b1;
        state_d              = S_DISP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.res_out = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // no request taken during the clearing pass
  a_clr_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !in_ready_o)
    else $error("request accepted while clearing");

  // table writes only in write states
  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr |-> (state_q == S_CLR || state_q == S_FIND_CK || state_q == S_DISP ||
                  state_q == S_MV_CK || state_q == S_MV_VAC))
    else $error("table write outside a write state");

  // a move is always followed by vacating its source
  a_move_vac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr && cmd_o.wr_sel == WR_MOVE) |=> (state_q == S_MV_VAC))
    else $error("move without vacate");

endmodule
